// ===== design/ilp_pkg.sv =====
// Package: shared types and constants of the IPv4 literal parser.
package ilp_pkg;

    // Parser position inside the current segment
    typedef enum logic [1:0] {
        PH_SEG_START  = 2'd0,
        PH_AFTER_ZERO = 2'd1,
        PH_DIGITS     = 2'd2
    } t_phase;

    // Radix of the current segment
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    // Classified character, as handed from the front to the back
    typedef struct packed {
        logic       is_end;   // end marker, no character
        logic [4:0] digit;    // digit value, DIGIT_NONE if no digit
        logic       is_dot;
        logic       is_x;     // 'x' or 'X'
        logic       is_zero;  // '0'
    } t_tok;

    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // Character codes
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [7:0] CHAR_UX    = 8'h58;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Limits of the parts
    localparam logic [31:0] MAX_OCTET = 32'h0000_00FF;
    localparam logic [31:0] MAX_16    = 32'h0000_FFFF;
    localparam logic [31:0] MAX_24    = 32'h00FF_FFFF;

    // Dot counts
    localparam logic [1:0] DOTS_0 = 2'd0;
    localparam logic [1:0] DOTS_1 = 2'd1;
    localparam logic [1:0] DOTS_2 = 2'd2;
    localparam logic [1:0] DOTS_3 = 2'd3;

    // Token queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

endpackage

// ===== design/ilp_in_if.sv =====
// Interface: character channel into the parser.
interface ilp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

// ===== design/ilp_out_if.sv =====
// Interface: result channel out of the parser.
interface ilp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] address;
    logic [1:0]  dots_seen;

    modport source (output valid, output valid_res, output address, output dots_seen,
                    input ready);
    modport sink   (input valid, input valid_res, input address, input dots_seen,
                    output ready);
endinterface

// ===== design/ilp_queue.sv =====
// Short token queue between the classifying front and the executing back.
module ilp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ilp_pkg::t_tok i_tok,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ilp_pkg::t_tok o_tok
);
    import ilp_pkg::*;

    t_tok              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_slot[r_rd_ptr];

    // Pointer and fill bookkeeping; depth is a power of two so pointers wrap
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_tok;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("token queue overfilled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty token queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full token queue");
`endif

endmodule

// ===== design/ilp_front.sv =====
// Front: accepts character beats and classifies them into tokens.
module ilp_front (
    ilp_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output ilp_pkg::t_tok o_tok
);
    import ilp_pkg::*;

    logic [7:0] c;

    assign c         = i_in.char_code;
    assign i_in.ready = !i_q_full;
    assign o_push    = i_in.valid && !i_q_full;

    // Character classification
    always_comb begin
        o_tok.is_end  = i_in.end_marker;
        o_tok.is_dot  = (c == CHAR_DOT);
        o_tok.is_x    = (c == CHAR_LX) || (c == CHAR_UX);
        o_tok.is_zero = (c == CHAR_0);
        priority if (c >= CHAR_0 && c <= CHAR_9) begin
            o_tok.digit = 5'(c - CHAR_0);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            o_tok.digit = 5'(c - CHAR_LA) + 5'd10;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            o_tok.digit = 5'(c - CHAR_UA) + 5'd10;
        end else begin
            o_tok.digit = DIGIT_NONE;
        end
    end

endmodule

// ===== design/ilp_back.sv =====
// Back: runs the segment accumulator and emits the result on the end marker.
module ilp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tok_valid,
    input  ilp_pkg::t_tok i_tok,
    output logic          o_pop,
    ilp_out_if.source     o_out
);
    import ilp_pkg::*;

    t_phase      r_phase, n_phase;
    t_radix      r_radix, n_radix;
    logic [31:0] r_seg, n_seg;
    logic        r_has, n_has;
    logic [1:0]  r_dot_count, n_dot_count;
    logic        r_failed, n_failed;
    logic [7:0]  r_octet [3];
    logic        oct_we;

    logic        r_out_valid;
    logic        r_valid_res;
    logic [31:0] r_address;
    logic [1:0]  r_dots;

    logic        pop, step, end_pop;
    t_radix      cur_radix;
    logic [31:0] seg_base;
    logic        lead_zero, hex_prefix, in_range, ovf, dot_ok;
    logic [35:0] seg_ext, prod;
    logic        res_ok;
    logic [31:0] res_addr;

    assign pop     = i_tok_valid && (!r_out_valid || o_out.ready);
    assign o_pop   = pop;
    assign end_pop = pop && i_tok.is_end;
    assign step    = pop && !i_tok.is_end && !r_failed;

    // Radix and base value in force for this character
    always_comb begin
        unique case (r_phase)
            PH_SEG_START:  cur_radix = RX_DEC;
            PH_AFTER_ZERO: cur_radix = RX_OCT;
            PH_DIGITS:     cur_radix = r_radix;
            default:       cur_radix = RX_DEC;
        endcase
    end
    assign seg_base   = (r_phase == PH_SEG_START) ? '0 : r_seg;
    assign lead_zero  = (r_phase == PH_SEG_START) && i_tok.is_zero;
    assign hex_prefix = (r_phase == PH_AFTER_ZERO) && i_tok.is_x;

    // Digit check and shift-add accumulate
    assign seg_ext = {4'b0, seg_base};
    always_comb begin
        unique case (cur_radix)
            RX_DEC: begin
                in_range = (i_tok.digit < 5'd10);
                prod     = (seg_ext << 3) + (seg_ext << 1) + {31'b0, i_tok.digit};
            end
            RX_OCT: begin
                in_range = (i_tok.digit < 5'd8);
                prod     = (seg_ext << 3) + {31'b0, i_tok.digit};
            end
            RX_HEX: begin
                in_range = !i_tok.digit[4];
                prod     = (seg_ext << 4) + {31'b0, i_tok.digit};
            end
            default: begin
                in_range = 1'b0;
                prod     = seg_ext;
            end
        endcase
    end
    assign ovf    = (prod[35:32] != 4'b0);
    assign dot_ok = (r_dot_count != DOTS_3) && r_has && (seg_base <= MAX_OCTET);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        priority if (end_pop) begin
            n_phase = PH_SEG_START;
        end else if (step) begin
            priority if (lead_zero) begin
                n_phase = PH_AFTER_ZERO;
            end else if (hex_prefix) begin
                n_phase = PH_DIGITS;
            end else if (!in_range && i_tok.is_dot && dot_ok) begin
                n_phase = PH_SEG_START;
            end else begin
                n_phase = PH_DIGITS;
            end
        end else begin
            n_phase = r_phase;
        end
    end

    // Segment datapath and flags
    always_comb begin
        n_radix     = r_radix;
        n_seg       = r_seg;
        n_has       = r_has;
        n_dot_count = r_dot_count;
        n_failed    = r_failed;
        oct_we      = 1'b0;
        priority if (end_pop) begin
            n_radix     = RX_DEC;
            n_seg       = '0;
            n_has       = 1'b0;
            n_dot_count = DOTS_0;
            n_failed    = 1'b0;
        end else if (step) begin
            priority if (lead_zero) begin
                n_seg   = '0;
                n_has   = 1'b1;
                n_radix = RX_DEC;
            end else if (hex_prefix) begin
                n_radix = RX_HEX;
                n_has   = 1'b0;
            end else begin
                n_radix = cur_radix;
                n_seg   = seg_base;
                priority if (in_range) begin
                    if (ovf) begin
                        n_failed = 1'b1;
                    end else begin
                        n_seg = prod[31:0];
                        n_has = 1'b1;
                    end
                end else if (i_tok.is_dot && dot_ok) begin
                    oct_we      = 1'b1;
                    n_dot_count = r_dot_count + 2'd1;
                    n_has       = 1'b0;
                    n_seg       = '0;
                end else begin
                    n_failed = 1'b1;
                end
            end
        end else begin
            n_failed = r_failed;
        end
    end

    // Final check of the last part and address assembly
    always_comb begin
        res_ok   = !r_failed && r_has && (r_phase != PH_SEG_START);
        res_addr = '0;
        unique case (r_dot_count)
            DOTS_0: res_addr = r_seg;
            DOTS_1: begin
                if (r_seg > MAX_24) res_ok = 1'b0;
                res_addr = {r_octet[0], r_seg[23:0]};
            end
            DOTS_2: begin
                if (r_seg > MAX_16) res_ok = 1'b0;
                res_addr = {r_octet[0], r_octet[1], r_seg[15:0]};
            end
            DOTS_3: begin
                if (r_seg > MAX_OCTET) res_ok = 1'b0;
                res_addr = {r_octet[0], r_octet[1], r_octet[2], r_seg[7:0]};
            end
            default: res_addr = '0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEG_START;
            r_radix     <= RX_DEC;
            r_has       <= 1'b0;
            r_dot_count <= DOTS_0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_radix     <= n_radix;
            r_has       <= n_has;
            r_dot_count <= n_dot_count;
            r_failed    <= n_failed;
            if (end_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Accumulator, dotted parts and result register
    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
        if (oct_we) begin
            unique case (r_dot_count)
                DOTS_0:  r_octet[0] <= seg_base[7:0];
                DOTS_1:  r_octet[1] <= seg_base[7:0];
                DOTS_2:  r_octet[2] <= seg_base[7:0];
                default: r_octet[0] <= r_octet[0];
            endcase
        end
        if (end_pop) begin
            r_valid_res <= res_ok;
            r_address   <= res_ok ? res_addr : '0;
            r_dots      <= res_ok ? r_dot_count : DOTS_0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.valid_res = r_valid_res;
    assign o_out.address   = r_address;
    assign o_out.dots_seen = r_dots;

`ifndef ASSERT_OFF
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_pop |=> r_phase == PH_SEG_START && r_dot_count == DOTS_0 && !r_failed && !r_has)
        else $error("parser state not cleared after end marker");
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !end_pop) |=> r_failed && $stable(r_dot_count))
        else $error("failed string changed state before end marker");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_valid_res) |-> (r_address == '0 && r_dots == DOTS_0))
        else $error("invalid result carries nonzero fields");
    a_dot_on_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oct_we |-> (step && i_tok.is_dot && r_dot_count != DOTS_3))
        else $error("dotted part stored without a legal dot");
`endif

endmodule

// ===== design/ipv4_literal_parser.sv =====
// Top level of the IPv4 literal parser.
// Usage:
//   i_in carries one character beat per item (char_code) or an end marker beat
//   (end_marker=1). Each string is closed by an end marker; an empty string
//   is reported invalid. Digits are decimal, octal after a leading 0, hex after 0x/0X.
//   o_out delivers one beat per end marker: valid_res, the address in host
//   order and the dot count; address and dots_seen are zero when invalid.
// Timing:
//   Characters are classified in the front and pushed into a two-entry token
//   queue; while no result beat waits on the receiver, the back consumes one
//   token per cycle and one beat is accepted every cycle. The end marker passes
//   through a queue slot, and the result register is loaded when it is popped.
// Reset and stall:
//   Synchronous active-low reset empties the queue and returns the parser to
//   segment start with no result pending. While the receiver holds ready low,
//   the result register holds its beat, the back stops, the queue fills and
//   i_in.ready drops once both queue slots are taken.
module ipv4_literal_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilp_in_if.sink     i_in,
    ilp_out_if.source  o_out
);
    import ilp_pkg::*;

    t_tok q_in_tok, q_out_tok;
    logic q_push, q_full, q_pop, q_valid;

    ilp_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_tok    (q_in_tok)
    );

    ilp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (q_in_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_tok   (q_out_tok)
    );

    ilp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_out_tok),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule
